// ===== src/rccd_pkg.sv =====
// Shared definitions for the conjugated complex dot product block.
// Holds default widths, the lane operation code and the lane control bundle.
package rccd_pkg;

  localparam int unsigned SampleWidthDef = 16;
  localparam int unsigned AccWidthDef    = 48;

  typedef enum logic {
    LANE_ADD = 1'b0,
    LANE_SUB = 1'b1
  } lane_op_e;

  typedef struct packed {
    logic step;
    logic clear;
  } lane_ctrl_t;

endpackage

// ===== src/rccd_cmul.sv =====
// Complex product stage: four signed sample products, registered.
// Depends on rccd_pkg for width defaults.
module rccd_cmul import rccd_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH = SampleWidthDef
) (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [SAMPLE_WIDTH-1:0]    x_real_i,
  input  logic signed [SAMPLE_WIDTH-1:0]    x_imag_i,
  input  logic signed [SAMPLE_WIDTH-1:0]    y_real_i,
  input  logic signed [SAMPLE_WIDTH-1:0]    y_imag_i,
  output logic signed [2*SAMPLE_WIDTH-1:0]  p_rr1_o,
  output logic signed [2*SAMPLE_WIDTH-1:0]  p_rr2_o,
  output logic signed [2*SAMPLE_WIDTH-1:0]  p_ri1_o,
  output logic signed [2*SAMPLE_WIDTH-1:0]  p_ri2_o
);

  localparam int unsigned ProdWidth = 2 * SAMPLE_WIDTH;

  logic signed [ProdWidth-1:0] rr1_d, rr2_d, ri1_d, ri2_d;
  logic signed [ProdWidth-1:0] rr1_q, rr2_q, ri1_q, ri2_q;

  assign rr1_d = x_real_i * y_real_i;
  assign rr2_d = x_imag_i * y_imag_i;
  assign ri1_d = x_real_i * y_imag_i;
  assign ri2_d = x_imag_i * y_real_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rr1_q <= rr1_d;
      rr2_q <= rr2_d;
      ri1_q <= ri1_d;
      ri2_q <= ri2_d;
    end
  end

  assign p_rr1_o = rr1_q;
  assign p_rr2_o = rr2_q;
  assign p_ri1_o = ri1_q;
  assign p_ri2_o = ri2_q;

endmodule

// ===== src/rccd_sat_acc.sv =====
// One saturating accumulator component: acc + a +/- b, clipped to ACC_WIDTH.
// Depends on rccd_pkg for the lane operation code and control bundle.
module rccd_sat_acc import rccd_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH = SampleWidthDef,
  parameter int unsigned ACC_WIDTH    = AccWidthDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  lane_ctrl_t                        ctrl_i,
  input  lane_op_e                          op_i,
  input  logic signed [2*SAMPLE_WIDTH-1:0]  p_a_i,
  input  logic signed [2*SAMPLE_WIDTH-1:0]  p_b_i,
  output logic signed [ACC_WIDTH-1:0]       sum_o,
  output logic                              clip_o,
  output logic signed [ACC_WIDTH-1:0]       acc_o
);

  localparam int unsigned ProdWidth = 2 * SAMPLE_WIDTH;
  localparam int unsigned SumWidth  = ((ACC_WIDTH > ProdWidth) ? ACC_WIDTH : ProdWidth) + 2;

  localparam logic signed [ACC_WIDTH-1:0] AccMax = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_WIDTH-1:0] AccMin = {1'b1, {(ACC_WIDTH-1){1'b0}}};

  logic signed [ACC_WIDTH-1:0] acc_d, acc_q;
  logic signed [SumWidth-1:0]  ext_acc, ext_a, ext_b, term_b, total;
  logic [SumWidth-ACC_WIDTH:0] top_bits;
  logic                        fits;

  assign ext_acc = {{(SumWidth-ACC_WIDTH){acc_q[ACC_WIDTH-1]}}, acc_q};
  assign ext_a   = {{(SumWidth-ProdWidth){p_a_i[ProdWidth-1]}}, p_a_i};
  assign ext_b   = {{(SumWidth-ProdWidth){p_b_i[ProdWidth-1]}}, p_b_i};

  always_comb begin
    case (op_i)
      LANE_SUB: term_b = -ext_b;
      default:  term_b = ext_b;
    endcase
  end

  assign total    = ext_acc + ext_a + term_b;
  assign top_bits = total[SumWidth-1:ACC_WIDTH-1];
  assign fits     = (&top_bits) | ~(|top_bits);

  always_comb begin
    if (fits) begin
      sum_o = total[ACC_WIDTH-1:0];
    end else if (total[SumWidth-1]) begin
      sum_o = AccMin;
    end else begin
      sum_o = AccMax;
    end
  end

  assign clip_o = ~fits;

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.step) begin
      acc_d = ctrl_i.clear ? '0 : sum_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

// ===== src/redundant_complex_conj_dot.sv =====
// Top level of the conjugated complex dot product with duplicated accumulators.
// Depends on rccd_pkg, rccd_cmul and rccd_sat_acc.
//
// Input channel: one element pair (x, y) per request, with last and
// empty_vector markers; in_valid_i / in_stall_o. Output channel: one result
// per vector; out_valid_o / out_stall_i. Each element adds conj(x)*y to two
// copies of a complex accumulator that saturate to ACC_WIDTH bits. The
// request marked last returns the sum (zero and mismatch if the copies
// differ); an empty_vector request returns zero and clears the partial sums.
// A result moves through the input, products, result and output registers in
// order. Throughput: one request per cycle while in_stall_o is low, set by
// the saturating add of each accumulator lane. Four pipeline stages (input,
// products, result, output) each hold one request, so requests that produce
// no result keep flowing while a result waits behind a stalled receiver; the
// input stalls only once every stage ahead of it is occupied.
// Reset empties the pipeline and clears both accumulator copies and the
// clip flag; the block is ready on the first cycle after reset.
module redundant_complex_conj_dot import rccd_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH = SampleWidthDef,
  parameter int unsigned ACC_WIDTH    = AccWidthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [SAMPLE_WIDTH-1:0] x_real_i,
  input  logic signed [SAMPLE_WIDTH-1:0] x_imag_i,
  input  logic signed [SAMPLE_WIDTH-1:0] y_real_i,
  input  logic signed [SAMPLE_WIDTH-1:0] y_imag_i,
  input  logic                           last_i,
  input  logic                           empty_vector_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [ACC_WIDTH-1:0]    sum_real_o,
  output logic signed [ACC_WIDTH-1:0]    sum_imag_o,
  output logic                           mismatch_o,
  output logic                           saturated_o
);

  localparam int unsigned ProdWidth = 2 * SAMPLE_WIDTH;

  logic v1_q, v2_q, v3_q, v4_q;
  logic r1, r2, r3, r4, fire2, res2, accept;

  logic signed [SAMPLE_WIDTH-1:0] xr1_q, xi1_q, yr1_q, yi1_q;
  logic                           last1_q, emp1_q, last2_q, emp2_q;

  logic signed [ProdWidth-1:0] p_rr1, p_rr2, p_ri1, p_ri2;

  lane_ctrl_t                  lane_ctrl;
  logic signed [ACC_WIDTH-1:0] sum_ar, sum_ai, sum_br, sum_bi;
  logic signed [ACC_WIDTH-1:0] acc_ar, acc_ai, acc_br, acc_bi;
  logic                        clip_ar, clip_ai, clip_br, clip_bi, clip_now;
  logic                        clip_seen_d, clip_seen_q;

  logic signed [ACC_WIDTH-1:0] fin_ar_q, fin_ai_q, fin_br_q, fin_bi_q;
  logic                        fin_clip_q;

  logic signed [ACC_WIDTH-1:0] sum_real_q, sum_imag_q;
  logic                        mism_d, mism_q, sat_q;

  assign r4     = ~v4_q | ~out_stall_i;
  assign r3     = ~v3_q | r4;
  assign res2   = last2_q | emp2_q;
  assign fire2  = v2_q & (~res2 | r3);
  assign r2     = ~v2_q | fire2;
  assign r1     = ~v1_q | r2;
  assign accept = in_valid_i & r1;

  assign in_stall_o = ~r1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (r1) begin
        v1_q <= in_valid_i;
      end
      if (r2) begin
        v2_q <= v1_q;
      end
      if (r3) begin
        v3_q <= fire2 & res2;
      end
      if (r4) begin
        v4_q <= v3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      xr1_q   <= x_real_i;
      xi1_q   <= x_imag_i;
      yr1_q   <= y_real_i;
      yi1_q   <= y_imag_i;
      last1_q <= last_i;
      emp1_q  <= empty_vector_i;
    end
    if (v1_q && r2) begin
      last2_q <= last1_q;
      emp2_q  <= emp1_q;
    end
  end

  rccd_cmul #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_cmul (
    .clk_i   (clk_i),
    .en_i    (v1_q & r2),
    .x_real_i(xr1_q),
    .x_imag_i(xi1_q),
    .y_real_i(yr1_q),
    .y_imag_i(yi1_q),
    .p_rr1_o (p_rr1),
    .p_rr2_o (p_rr2),
    .p_ri1_o (p_ri1),
    .p_ri2_o (p_ri2)
  );

  assign lane_ctrl.step  = fire2;
  assign lane_ctrl.clear = res2;

  rccd_sat_acc #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .ACC_WIDTH   (ACC_WIDTH)
  ) u_acc_a_real (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(lane_ctrl),
    .op_i  (LANE_ADD),
    .p_a_i (p_rr1),
    .p_b_i (p_rr2),
    .sum_o (sum_ar),
    .clip_o(clip_ar),
    .acc_o (acc_ar)
  );

  rccd_sat_acc #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .ACC_WIDTH   (ACC_WIDTH)
  ) u_acc_a_imag (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(lane_ctrl),
    .op_i  (LANE_SUB),
    .p_a_i (p_ri1),
    .p_b_i (p_ri2),
    .sum_o (sum_ai),
    .clip_o(clip_ai),
    .acc_o (acc_ai)
  );

  rccd_sat_acc #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .ACC_WIDTH   (ACC_WIDTH)
  ) u_acc_b_real (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(lane_ctrl),
    .op_i  (LANE_ADD),
    .p_a_i (p_rr1),
    .p_b_i (p_rr2),
    .sum_o (sum_br),
    .clip_o(clip_br),
    .acc_o (acc_br)
  );

  rccd_sat_acc #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .ACC_WIDTH   (ACC_WIDTH)
  ) u_acc_b_imag (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(lane_ctrl),
    .op_i  (LANE_SUB),
    .p_a_i (p_ri1),
    .p_b_i (p_ri2),
    .sum_o (sum_bi),
    .clip_o(clip_bi),
    .acc_o (acc_bi)
  );

  assign clip_now = (clip_ar | clip_ai | clip_br | clip_bi) & ~emp2_q;

  always_comb begin
    clip_seen_d = clip_seen_q;
    if (fire2) begin
      clip_seen_d = res2 ? 1'b0 : (clip_seen_q | clip_now);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_seen_q <= 1'b0;
    end else begin
      clip_seen_q <= clip_seen_d;
    end
  end

  // capture the finished vector; an empty vector yields a clean zero
  always_ff @(posedge clk_i) begin
    if (fire2 && res2) begin
      if (emp2_q) begin
        fin_ar_q   <= '0;
        fin_ai_q   <= '0;
        fin_br_q   <= '0;
        fin_bi_q   <= '0;
        fin_clip_q <= 1'b0;
      end else begin
        fin_ar_q   <= sum_ar;
        fin_ai_q   <= sum_ai;
        fin_br_q   <= sum_br;
        fin_bi_q   <= sum_bi;
        fin_clip_q <= clip_seen_q | clip_now;
      end
    end
  end

  assign mism_d = (fin_ar_q != fin_br_q) || (fin_ai_q != fin_bi_q);

  always_ff @(posedge clk_i) begin
    if (v3_q && r4) begin
      sum_real_q <= mism_d ? '0 : fin_ar_q;
      sum_imag_q <= mism_d ? '0 : fin_ai_q;
      mism_q     <= mism_d;
      sat_q      <= fin_clip_q;
    end
  end

  assign out_valid_o = v4_q;
  assign sum_real_o  = sum_real_q;
  assign sum_imag_o  = sum_imag_q;
  assign mismatch_o  = mism_q;
  assign saturated_o = sat_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_ar == acc_br) && (acc_ai == acc_bi))
    else $error("redundant accumulator copies diverged");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire2 && res2 |=> v3_q && (acc_ar == '0) && (acc_ai == '0) && !clip_seen_q)
    else $error("vector end did not clear accumulators or queue a result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire2 && emp2_q |=> (fin_ar_q == '0) && (fin_ai_q == '0) && !fin_clip_q)
    else $error("empty vector produced a non-zero result");
`endif

endmodule
